[hdl/wlf_pkg.sv]
// shared types, constants and helpers of the word length filter
package wlf_pkg;

    localparam int MAX_WORD   = 32;
    localparam int ADDR_W     = $clog2(MAX_WORD);
    localparam int CNT_W      = $clog2(MAX_WORD + 1);
    localparam int LEN_W      = 6;
    localparam int CMP_W      = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int BYTE_W     = 8;
    localparam int FIFO_DEPTH = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(8);
    localparam logic             REG_MAX_LEN   = 1'b0;

    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_Z  = 8'h5A;

    typedef struct packed {
        logic [BYTE_W-1:0] delim;
        logic [CNT_W-1:0]  count;
    } cmd_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WAIT,
        BK_LOAD,
        BK_DELIM
    } back_state_t;

    function automatic logic wlf_is_delim(input logic [BYTE_W-1:0] b);
        return (b == CH_SPACE) || (b == CH_DOT) || (b == CH_COMMA) ||
               (b == CH_LF) || (b == CH_NUL);
    endfunction

    function automatic logic wlf_is_letter(input logic [BYTE_W-1:0] b);
        return ((b >= CH_LO_A) && (b <= CH_LO_Z)) || ((b >= CH_UP_A) && (b <= CH_UP_Z));
    endfunction

endpackage

[hdl/wlf_ram.sv]
// generic single write port ram with registered read
module wlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/wlf_front.sv]
// input side: takes beats, collects the word and queues emit commands
module wlf_front
    import wlf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] in_byte
    input  logic [LEN_W-1:0]  max_len,
    input  fifo_stat_t        fifo_stat,
    input  logic              back_idle,
    output ram_wr_t           ram_wr,
    output logic              cmd_push,
    output cmd_t              cmd
);

    logic [CNT_W-1:0] word_count_reg, word_count_next;
    logic             in_word_reg, in_word_next;
    logic             bad_char_reg, bad_char_next;
    logic             too_long_reg, too_long_next;

    logic             delim;
    logic             s_fire;
    logic             store_full;
    logic             word_ok;
    logic [CNT_W-1:0] count_inc;

    always_comb begin
        delim      = wlf_is_delim(s_tdata);
        s_tready   = delim ? !fifo_stat.full : (fifo_stat.empty && back_idle);
        s_fire     = s_tvalid && s_tready;
        store_full = (word_count_reg >= CNT_W'(MAX_WORD));
        word_ok    = in_word_reg && !bad_char_reg && !too_long_reg;
        count_inc  = word_count_reg + CNT_W'(1);

        ram_wr.en   = s_fire && !delim && !store_full;
        ram_wr.addr = word_count_reg[ADDR_W-1:0];
        ram_wr.data = s_tdata;

        cmd_push  = s_fire && delim && (word_ok || (s_tdata == CH_NUL));
        cmd.delim = s_tdata;
        cmd.count = word_ok ? word_count_reg : '0;
    end

    always_comb begin
        word_count_next = word_count_reg;
        in_word_next    = in_word_reg;
        bad_char_next   = bad_char_reg;
        too_long_next   = too_long_reg;
        if (s_fire) begin
            if (delim) begin
                word_count_next = '0;
                in_word_next    = 1'b0;
                bad_char_next   = 1'b0;
                too_long_next   = 1'b0;
            end else begin
                in_word_next = 1'b1;
                if (!wlf_is_letter(s_tdata)) begin
                    bad_char_next = 1'b1;
                end
                if (store_full) begin
                    too_long_next = 1'b1;
                end else begin
                    word_count_next = count_inc;
                    if (CMP_W'(count_inc) > CMP_W'(max_len)) begin
                        too_long_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_count_reg <= '0;
            in_word_reg    <= 1'b0;
            bad_char_reg   <= 1'b0;
            too_long_reg   <= 1'b0;
        end else begin
            word_count_reg <= word_count_next;
            in_word_reg    <= in_word_next;
            bad_char_reg   <= bad_char_next;
            too_long_reg   <= too_long_next;
        end
    end

endmodule

[hdl/wlf_cmd_fifo.sv]
// short command queue between the front and the back
module wlf_cmd_fifo
    import wlf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  cmd_t       push_data,
    input  logic       pop,
    output cmd_t       pop_data,
    output fifo_stat_t stat
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

    cmd_t              slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    always_comb begin
        stat.full  = (fill_reg == FCNT_W'(FIFO_DEPTH));
        stat.empty = (fill_reg == '0);
        do_push    = push && !stat.full;
        do_pop     = pop && !stat.empty;
        pop_data   = slot_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   fill_next = fill_reg + FCNT_W'(1);
            2'b01:   fill_next = fill_reg - FCNT_W'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/wlf_back.sv]
// output side: replays a kept word from the store, then its delimiter
module wlf_back
    import wlf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    input  logic              cmd_empty,
    output logic              cmd_pop,
    output logic [ADDR_W-1:0] raddr,
    input  logic [BYTE_W-1:0] rdata,
    output logic              idle,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // [7:0] out_byte
    output logic              m_tlast
);

    back_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    cmd_t              cur_reg, cur_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [BYTE_W-1:0] m_tdata_reg, m_tdata_next;
    logic              m_tlast_reg, m_tlast_next;
    logic              out_free;
    logic              last_byte;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign last_byte = ((idx_reg + CNT_W'(1)) == cur_reg.count);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (!cmd_empty) begin
                    state_next = (cmd.count == '0) ? BK_DELIM : BK_WAIT;
                end
            end
            BK_WAIT: state_next = BK_LOAD;
            BK_LOAD: begin
                if (out_free) begin
                    state_next = last_byte ? BK_DELIM : BK_WAIT;
                end
            end
            BK_DELIM: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        cmd_pop       = 1'b0;
        idx_next      = idx_reg;
        cur_next      = cur_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (!cmd_empty) begin
                    cmd_pop  = 1'b1;
                    cur_next = cmd;
                    idx_next = '0;
                end
            end
            BK_WAIT: ;
            BK_LOAD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = rdata;
                    m_tlast_next  = 1'b0;
                    idx_next      = idx_reg + CNT_W'(1);
                end
            end
            BK_DELIM: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = cur_reg.delim;
                    m_tlast_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        cur_reg     <= cur_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign raddr    = idx_reg[ADDR_W-1:0];
    assign idle     = (state_reg == BK_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[hdl/word_length_filter.sv]
// top level of the word length filter
//
// text bytes enter on the s_ stream one beat each; a word is a run of bytes
// between space, period, comma, newline or the zero byte. a word made only
// of latin letters and no longer than max_word_length is sent on the m_
// stream followed by its delimiter, tlast on the delimiter. other words and
// their delimiters are dropped, as is a delimiter with no word. a zero byte
// always yields one zero beat with tlast, after any kept word.
// word bytes are taken one per cycle while no earlier word is being sent;
// delimiters are taken one per cycle while the two entry command queue has
// room. the back part pops a command, then reads each word byte from the
// store (a wait state and a load state per byte) and sends the delimiter
// last. a stalled m_ side holds its beat in the output register; the queue
// takes delimiters until it is full, then s_tready drops. reset clears the
// word state, the queue and the output, and sets max_word_length (apb
// register at offset 0) to 8.
module word_length_filter
    import wlf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] in_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [BYTE_W-1:0]     m_tdata,   // [7:0] out_byte
    output logic                  m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [LEN_W-1:0]  max_len_reg, max_len_next;
    logic              cfg_wr;
    fifo_stat_t        fifo_stat;
    logic              back_idle;
    ram_wr_t           ram_wr;
    logic              cmd_push, cmd_pop;
    cmd_t              cmd_in, cmd_out;
    logic [ADDR_W-1:0] raddr;
    logic [BYTE_W-1:0] rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_LEN);
    assign prdata = (paddr[2] == REG_MAX_LEN) ? APB_DATA_W'(max_len_reg) : '0;

    always_comb begin
        max_len_next = max_len_reg;
        if (cfg_wr) begin
            max_len_next = pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else begin
            max_len_reg <= max_len_next;
        end
    end

    wlf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .max_len   (max_len_reg),
        .fifo_stat (fifo_stat),
        .back_idle (back_idle),
        .ram_wr    (ram_wr),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    wlf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_WORD)
    ) u_word_ram (
        .aclk  (aclk),
        .we    (ram_wr.en),
        .waddr (ram_wr.addr),
        .wdata (ram_wr.data),
        .raddr (raddr),
        .rdata (rdata)
    );

    wlf_cmd_fifo u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_data (cmd_in),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .stat      (fifo_stat)
    );

    wlf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd_out),
        .cmd_empty (fifo_stat.empty),
        .cmd_pop   (cmd_pop),
        .raddr     (raddr),
        .rdata     (rdata),
        .idle      (back_idle),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_push |-> !fifo_stat.full)
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> !fifo_stat.empty)
        else $error("command popped from an empty queue");

    a_store_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr.en |-> (back_idle && fifo_stat.empty))
        else $error("word store written while a word is being sent");

    a_nul_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata == CH_NUL)) |-> m_tlast)
        else $error("zero byte sent without tlast");

endmodule

[verif/testbench.sv]
// self-checking stream testbench for the word length filter
module testbench;
    import wlf_pkg::*;

    localparam int REG_COUNT  = 1;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_WAIT = 20;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } out_beat_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_style_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [BYTE_W-1:0]     m_tdata;
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // text still to be sent and filtered bytes still to arrive
    logic [BYTE_W-1:0] text_q[$];
    out_beat_t         out_expect[$];
    int                fails       = 0;
    int                items_taken = 0;

    // filter state as the block should hold it
    logic [BYTE_W-1:0] word_buf [MAX_WORD];
    logic [LEN_W-1:0]  word_len  = '0;
    logic [LEN_W-1:0]  max_len   = MAX_LEN_RESET;
    bit                in_word_q = 1'b0;
    bit                has_bad   = 1'b0;
    bit                over_len  = 1'b0;

    int        burst_left = 0;
    int        gap_left   = 0;
    int        hold_left  = 0;
    int        hold_mark  = -1;
    int        mode_left  = 0;
    int        rx_tick    = 0;
    rx_style_t rx_mode    = RX_FREE;
    bit        rx_rdy;
    out_beat_t got_exp;

    word_length_filter u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] in_byte
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [7:0] out_byte
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit is_sep(input logic [BYTE_W-1:0] b);
        return b == CH_SPACE || b == CH_DOT || b == CH_COMMA || b == CH_LF || b == CH_NUL;
    endfunction

    function automatic bit is_alpha(input logic [BYTE_W-1:0] b);
        return (b >= CH_LO_A && b <= CH_LO_Z) || (b >= CH_UP_A && b <= CH_UP_Z);
    endfunction

    task automatic filter_byte(input logic [BYTE_W-1:0] b);
        int k;
        if (!is_sep(b)) begin
            if (!is_alpha(b))
                has_bad = 1'b1;
            if (word_len >= MAX_WORD) begin
                over_len = 1'b1;
            end else begin
                word_buf[word_len[ADDR_W-1:0]] = b;
                word_len = word_len + 1'b1;
                if (word_len > max_len)
                    over_len = 1'b1;
            end
            in_word_q = 1'b1;
        end else begin
            if (in_word_q && !has_bad && !over_len) begin
                for (k = 0; k < word_len; k++)
                    out_expect.push_back('{data: word_buf[k], last: 1'b0});
                out_expect.push_back('{data: b, last: 1'b1});
            end else if (b == CH_NUL) begin
                out_expect.push_back('{data: CH_NUL, last: 1'b1});
            end
            word_len  = '0;
            in_word_q = 1'b0;
            has_bad   = 1'b0;
            over_len  = 1'b0;
        end
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (s_tvalid) begin
                filter_byte(s_tdata);
                void'(text_q.pop_front());
                items_taken++;
            end
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (text_q.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= text_q[0];
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off while the sender keeps going
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if ((items_taken >= 70 && hold_mark < 70) ||
                     (items_taken >= 230 && hold_mark < 230)) begin
            hold_left <= HOLD_LEN;
            hold_mark <= items_taken;
        end
    end

    // receiver: picks a new random stall style whenever its mode counter runs out
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_tick <= rx_tick + 1;
            if (mode_left == 0) begin
                rx_mode   <= rx_style_t'($urandom_range(0, 3));
                mode_left <= $urandom_range(16, 96);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_FREE:     rx_rdy = 1'b1;
                RX_COIN:     rx_rdy = ($urandom_range(0, 1) == 1);
                RX_SPARSE:   rx_rdy = ($urandom_range(0, 3) == 0);
                RX_PERIODIC: rx_rdy = (rx_tick % 4) != 3;
                default:     rx_rdy = 1'b1;
            endcase
            m_tready <= rx_rdy && hold_left == 0;
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (out_expect.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual data %02h last %0b",
                         $time, m_tdata, m_tlast);
                fails++;
            end else begin
                got_exp = out_expect.pop_front();
                if (m_tdata !== got_exp.data) begin
                    $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                             $time, got_exp.data, m_tdata);
                    fails++;
                end
                if (m_tlast !== got_exp.last) begin
                    $display("%0t: last mismatch, expected %0b, actual %0b",
                             $time, got_exp.last, m_tlast);
                    fails++;
                end
            end
        end
    end

    task automatic apb_write(input int index, input logic [APB_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * index);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == int'(REG_MAX_LEN))
            max_len = value[LEN_W-1:0];
    endtask

    task automatic wait_idle();
        while (text_q.size() > 0 || s_tvalid || out_expect.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic push_str(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            text_q.push_back(s[k]);
    endtask

    function automatic logic [BYTE_W-1:0] rand_junk();
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(0, 255));
        while (is_sep(b) || is_alpha(b));
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] rand_sep();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_DOT;
            2:       return CH_COMMA;
            default: return CH_LF;
        endcase
    endfunction

    // random text: mostly well-formed words around the length limit
    task automatic add_text(input int n_items);
        int start;
        int len;
        int lim;
        int junk_at;
        int k;
        start = text_q.size();
        lim   = (max_len > MAX_WORD) ? MAX_WORD : max_len;
        while (text_q.size() - start < n_items) begin
            if ($urandom_range(0, 99) < 6) begin
                text_q.push_back(BYTE_W'($urandom_range(0, 255)));
            end else begin
                case ($urandom_range(0, 19))
                    0, 1:    len = 0;
                    2, 3:    len = $urandom_range(20, 40);
                    default: len = $urandom_range(1, lim + 1);
                endcase
                junk_at = ($urandom_range(0, 6) == 0 && len > 0) ? $urandom_range(0, len - 1) : -1;
                for (k = 0; k < len; k++) begin
                    if (k == junk_at)
                        text_q.push_back(rand_junk());
                    else
                        text_q.push_back(BYTE_W'($urandom_range(0, 25) +
                                         ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A)));
                end
                if ($urandom_range(0, 9) == 0)
                    text_q.push_back(CH_NUL);
                else
                    text_q.push_back(rand_sep());
                if ($urandom_range(0, 9) == 0)
                    text_q.push_back(rand_sep());
            end
        end
        text_q.push_back(CH_NUL);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // letter range edges, non-letter neighbours, lone delimiters, byte extremes
        push_str("AZaz");
        text_q.push_back(CH_SPACE);
        text_q.push_back(CH_UP_A - 1'b1);
        text_q.push_back(CH_UP_Z + 1'b1);
        text_q.push_back(CH_LO_A - 1'b1);
        text_q.push_back(CH_LO_Z + 1'b1);
        text_q.push_back(CH_COMMA);
        text_q.push_back(CH_DOT);
        text_q.push_back(8'hFF);
        text_q.push_back(CH_LF);
        push_str("b");
        text_q.push_back(CH_NUL);
        text_q.push_back(CH_NUL);
        add_text(50);
        wait_idle();

        apb_write(int'(REG_MAX_LEN), 32'd1);
        @(negedge aclk);
        push_str("ab");
        text_q.push_back(CH_SPACE);
        push_str("q");
        text_q.push_back(CH_SPACE);
        add_text(35);
        wait_idle();

        apb_write(int'(REG_MAX_LEN), 32'd0);
        @(negedge aclk);
        push_str("a");
        text_q.push_back(CH_DOT);
        add_text(25);
        wait_idle();

        // upper bits of the write data are not part of the register
        apb_write(int'(REG_MAX_LEN), 32'hFFFF_FFE0);
        apb_write(REG_COUNT, 32'd3);
        @(negedge aclk);
        add_text(60);
        wait_idle();

        apb_write(int'(REG_MAX_LEN), 32'd63);
        @(negedge aclk);
        add_text(60);
        wait_idle();

        apb_write(int'(REG_MAX_LEN), $urandom_range(2, 20));
        @(negedge aclk);
        add_text(60);
        wait_idle();

        if (fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
